>>> hdl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by jsu_decode, jsu_out_buf and json_string_unescaper_unit.
package jsu_pkg;

    localparam int BYTE_W = 8;
    localparam int HEX_W  = 16;

    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_U         = 8'h75;
    localparam logic [BYTE_W-1:0] CH_T         = 8'h74;
    localparam logic [BYTE_W-1:0] CH_N         = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R         = 8'h72;
    localparam logic [BYTE_W-1:0] CH_B         = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F         = 8'h66;
    localparam logic [BYTE_W-1:0] CTL_TAB      = 8'h09;
    localparam logic [BYTE_W-1:0] CTL_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] CTL_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CTL_BS       = 8'h08;
    localparam logic [BYTE_W-1:0] CTL_FF       = 8'h0C;
    localparam logic [HEX_W-1:0]  CODE_LOW     = 16'h0020;
    localparam logic [HEX_W-1:0]  CODE_HIGH    = 16'h007E;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX   = 2'd2
    } t_mode;

    // Decoded results of one input transaction (zero, one or two bytes)
    typedef struct packed {
        logic [1:0]        cnt;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic              has0;
        logic              str_end;
    } t_dec_res;

    // Hex digit decode: bit 4 set when the character is a valid digit
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b1, 4'(c - 8'h37)};
        end
        return d;
    endfunction

endpackage

>>> hdl/jsu_decode.sv
// Escape decoder: mode state machine, \u digit accumulator and result forming.
// Depends on jsu_pkg.
module jsu_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [jsu_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    output jsu_pkg::t_dec_res          o_res
);

    jsu_pkg::t_mode              r_mode, n_mode;
    logic [1:0]                  r_hex_cnt, n_hex_cnt;
    logic [jsu_pkg::HEX_W-1:0]   r_hex_val, n_hex_val;
    logic                        r_hex_bad, n_hex_bad;

    logic [4:0]                  dig;
    logic [jsu_pkg::HEX_W-1:0]   acc_val;
    logic                        acc_bad;
    logic [1:0]                  cnt;
    logic [jsu_pkg::BYTE_W-1:0]  b0, b1;

    assign dig     = jsu_pkg::hex_digit(i_byte);
    assign acc_val = dig[4] ? {r_hex_val[jsu_pkg::HEX_W-5:0], dig[3:0]} : r_hex_val;
    assign acc_bad = r_hex_bad | ~dig[4];

    // Next state
    always_comb begin
        n_mode = jsu_pkg::MODE_PLAIN;
        unique case (r_mode)
            jsu_pkg::MODE_ESC: begin
                if (i_byte == jsu_pkg::CH_U && !i_last) n_mode = jsu_pkg::MODE_HEX;
            end
            jsu_pkg::MODE_HEX: begin
                if (r_hex_cnt != 2'd3 && !i_last) n_mode = jsu_pkg::MODE_HEX;
            end
            default: begin
                if (i_byte == jsu_pkg::CH_BACKSLASH && !i_last) n_mode = jsu_pkg::MODE_ESC;
            end
        endcase
    end

    // Outputs and accumulator update
    always_comb begin
        cnt       = 2'd0;
        b0        = i_byte;
        b1        = i_byte;
        n_hex_cnt = 2'd0;
        n_hex_val = '0;
        n_hex_bad = 1'b0;
        unique case (r_mode)
            jsu_pkg::MODE_ESC: begin
                cnt = 2'd1;
                unique case (i_byte)
                    jsu_pkg::CH_QUOTE:     b0 = jsu_pkg::CH_QUOTE;
                    jsu_pkg::CH_BACKSLASH: b0 = jsu_pkg::CH_BACKSLASH;
                    jsu_pkg::CH_T:         b0 = jsu_pkg::CTL_TAB;
                    jsu_pkg::CH_N:         b0 = jsu_pkg::CTL_LF;
                    jsu_pkg::CH_R:         b0 = jsu_pkg::CTL_CR;
                    jsu_pkg::CH_B:         b0 = jsu_pkg::CTL_BS;
                    jsu_pkg::CH_F:         b0 = jsu_pkg::CTL_FF;
                    jsu_pkg::CH_U:         cnt = 2'd0;
                    default: begin
                        cnt = 2'd2;
                        b0  = jsu_pkg::CH_BACKSLASH;
                    end
                endcase
            end
            jsu_pkg::MODE_HEX: begin
                b0 = acc_val[jsu_pkg::BYTE_W-1:0];
                if (r_hex_cnt == 2'd3) begin
                    if (!acc_bad && acc_val >= jsu_pkg::CODE_LOW
                            && acc_val <= jsu_pkg::CODE_HIGH) begin
                        cnt = 2'd1;
                    end
                end else begin
                    n_hex_cnt = r_hex_cnt + 2'd1;
                    n_hex_val = acc_val;
                    n_hex_bad = acc_bad;
                end
            end
            default: begin
                if (!(i_byte == jsu_pkg::CH_BACKSLASH && !i_last)) cnt = 2'd1;
            end
        endcase
        // End of string with nothing decoded: a bare end marker
        o_res.has0    = 1'b1;
        if (cnt == 2'd0 && i_last) begin
            cnt        = 2'd1;
            b0         = '0;
            o_res.has0 = 1'b0;
        end
        if (i_last) begin
            n_hex_cnt = 2'd0;
            n_hex_val = '0;
            n_hex_bad = 1'b0;
        end
        o_res.cnt     = cnt;
        o_res.byte0   = b0;
        o_res.byte1   = b1;
        o_res.str_end = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsu_pkg::MODE_PLAIN;
            r_hex_cnt <= 2'd0;
            r_hex_val <= '0;
            r_hex_bad <= 1'b0;
        end else if (i_adv) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_hex_val <= n_hex_val;
            r_hex_bad <= n_hex_bad;
        end
    end

endmodule

>>> hdl/jsu_out_buf.sv
// Result register: holds up to two decoded bytes and sends them one per transaction.
// Depends on jsu_pkg.
module jsu_out_buf (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  jsu_pkg::t_dec_res          i_res,
    output logic                       o_free,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]                 m_axis_tuser,  // [0] out_has_byte, [1] out_run_last
    output logic                       m_axis_tlast   // out_string_end
);

    logic [1:0]                  r_rem;
    logic                        r_pos;
    logic [jsu_pkg::BYTE_W-1:0]  r_byte0, r_byte1;
    logic                        r_has0;
    logic                        r_end;
    logic                        pop;
    logic                        run_last;

    assign pop      = m_axis_tvalid & m_axis_tready;
    assign o_free   = (r_rem == 2'd0) || (r_rem == 2'd1 && m_axis_tready);
    assign run_last = (r_rem == 2'd1);

    assign m_axis_tvalid = (r_rem != 2'd0);
    assign m_axis_tdata  = r_pos ? r_byte1 : r_byte0;
    assign m_axis_tuser  = {run_last, r_pos | r_has0};
    assign m_axis_tlast  = run_last & r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
            r_pos <= 1'b0;
        end else if (i_load) begin
            r_rem <= i_res.cnt;
            r_pos <= 1'b0;
        end else if (pop) begin
            r_rem <= r_rem - 2'd1;
            r_pos <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte0 <= i_res.byte0;
            r_byte1 <= i_res.byte1;
            r_has0  <= i_res.has0;
            r_end   <= i_res.str_end;
        end
    end

endmodule

>>> hdl/json_string_unescaper_unit.sv
// JSON string unescaper, top level: input register, escape decoder, result register.
// Each input byte passes through the input register, then the decoder, into the result register.
// Throughput: one input byte per cycle while the output accepts results; an unknown escape yields two
//   results and holds the input side while the second result drains from the result register.
// Reset (i_rst_n low at a clock edge, synchronous) empties both registers and returns the
//   decoder to plain mode with a cleared \u accumulator. Depends on jsu_pkg.
module json_string_unescaper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [0] out_has_byte, [1] out_run_last
    output logic        m_axis_tlast    // out_string_end
);

    // Input register: one byte and its end-of-string flag
    logic                        r_in_valid;
    logic [jsu_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_in_last;

    jsu_pkg::t_dec_res           dec_res;
    logic                        out_free;
    logic                        adv;

    // Advance the held byte through the decoder once the result register can take
    // its results; bytes that produce nothing also advance here and just update state.
    assign adv           = r_in_valid & out_free;
    assign s_axis_tready = ~r_in_valid | adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (dec_res)
    );

    // Load only when the byte produced at least one result (an end marker counts)
    jsu_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (adv && dec_res.cnt != 2'd0),
        .i_res         (dec_res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
